// File: hdl/shc_pkg.sv
// Shared types, constants and the SipHash round function for the
// address challenge engine. No dependencies.
package shc_pkg;

   localparam int unsigned SIP_ROUNDS = 12;   // 4 message blocks x 2 + 4 final
   localparam int unsigned MSG_BYTES  = 28;

   localparam logic [63:0] IV0 = 64'h736f6d6570736575;
   localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
   localparam logic [63:0] IV2 = 64'h6c7967656e657261;
   localparam logic [63:0] IV3 = 64'h7465646279746573;

   typedef logic [3:0][63:0] sip_vec_type;

   // Everything one pipeline cell hands to the next
   typedef struct packed {
      sip_vec_type v_cur;
      sip_vec_type v_prv;
      sip_vec_type m_cur;
      sip_vec_type m_prv;
      logic        is_verify;
      logic        prev_ok;
      logic [63:0] claimed;
   } cell_data_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
      rotl = (x << r) | (x >> (64 - r));
   endfunction

   function automatic sip_vec_type sip_round(input sip_vec_type vi);
      sip_vec_type v;
      v = vi;
      v[0] = v[0] + v[1]; v[1] = rotl(v[1], 13); v[1] = v[1] ^ v[0]; v[0] = rotl(v[0], 32);
      v[2] = v[2] + v[3]; v[3] = rotl(v[3], 16); v[3] = v[3] ^ v[2];
      v[0] = v[0] + v[3]; v[3] = rotl(v[3], 21); v[3] = v[3] ^ v[0];
      v[2] = v[2] + v[1]; v[1] = rotl(v[1], 17); v[1] = v[1] ^ v[2]; v[2] = rotl(v[2], 32);
      sip_round = v;
   endfunction

endpackage

// File: hdl/siphash_address_challenge.sv
// Top level of the SipHash-2-4 address challenge engine: key registers,
// message packing, a chain of round cells and the result register.
// Depends on shc_pkg and shc_cell.
//
//  channel | direction | handshake          | contents
//  req_    | in        | req_tvalid/tready  | peer address, port, bucket, claim
//  rsp_    | out       | rsp_tvalid/tready  | hash and match flag
//  csr_    | in        | csr_valid/ready    | key register writes
//
// One request per cycle unless rsp_tready stalls; 12 round cells, one result
// register. Each cell hashes the current and the previous bucket side by side.
// Reset (synchronous) clears all valid bits and the key to zero.
// A stalled result holds its stage; earlier cells keep filling empty slots.
module siphash_address_challenge (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [15:0] addr_family, [31:16] port_wire, [95:32] addr_upper,
   // [159:96] addr_lower, [223:160] time_bucket, [287:224] claimed_value
   input  logic [287:0] req_tdata,
   // [0] req_type
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] hash_value, [64] matched, [71:65] zero
   output logic [71:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [63:0]  csr_data
);
   import shc_pkg::*;

   localparam logic [7:0] LenByte = 8'(MSG_BYTES);

   logic [63:0] key_low_ff, key_high_ff;

   // Key registers, writable any time
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == 1'b0) key_low_ff  <= csr_data;
         else                   key_high_ff <= csr_data;
      end
   end

   // Field unpacking
   logic [15:0] fam, port;
   logic [63:0] up, lo, bucket, bucket_m1, claimed;
   assign fam     = req_tdata[15:0];
   assign port    = req_tdata[31:16];
   assign up      = req_tdata[95:32];
   assign lo      = req_tdata[159:96];
   assign bucket  = req_tdata[223:160];
   assign claimed = req_tdata[287:224];
   assign bucket_m1 = bucket - 64'd1;

   // Message words and initial state
   cell_data_type head;
   sip_vec_type   vinit;
   always_comb begin
      vinit[0] = key_low_ff  ^ IV0;
      vinit[1] = key_high_ff ^ IV1;
      vinit[2] = key_low_ff  ^ IV2;
      vinit[3] = key_high_ff ^ IV3;
      head.v_cur = vinit;
      head.v_prv = vinit;
      head.m_cur[0] = {up[39:32], up[47:40], up[55:48], up[63:56],
                       port[7:0], port[15:8], fam};
      head.m_cur[1] = {lo[39:32], lo[47:40], lo[55:48], lo[63:56],
                       up[7:0], up[15:8], up[23:16], up[31:24]};
      head.m_cur[2] = {bucket[31:0], lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
      head.m_cur[3] = {LenByte, 24'd0, bucket[63:32]};
      head.m_prv    = head.m_cur;
      head.m_prv[2] = {bucket_m1[31:0], lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
      head.m_prv[3] = {LenByte, 24'd0, bucket_m1[63:32]};
      head.is_verify = req_tuser;
      head.prev_ok   = req_tuser && (bucket != 64'd0);
      head.claimed   = claimed;
   end

   // Chain of round cells
   logic          ch_valid [SIP_ROUNDS+1];
   logic          ch_ready [SIP_ROUNDS+1];
   cell_data_type ch_data  [SIP_ROUNDS+1];

   assign ch_valid[0] = req_tvalid;
   assign req_tready  = ch_ready[0];
   assign ch_data[0]  = head;

   for (genvar g = 0; g < SIP_ROUNDS; g++) begin : g_cell
      shc_cell #(.RoundIdx(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_valid[g]),
         .in_ready  (ch_ready[g]),
         .in_data   (ch_data[g]),
         .out_valid (ch_valid[g+1]),
         .out_ready (ch_ready[g+1]),
         .out_data  (ch_data[g+1])
      );
   end

   // Result register: fold state, compare claims
   logic        res_valid_ff;
   logic [63:0] hash_ff, hash_in, hprv;
   logic        match_ff, match_in;
   cell_data_type tail;

   assign tail    = ch_data[SIP_ROUNDS];
   assign hash_in = tail.v_cur[0] ^ tail.v_cur[1] ^ tail.v_cur[2] ^ tail.v_cur[3];
   assign hprv    = tail.v_prv[0] ^ tail.v_prv[1] ^ tail.v_prv[2] ^ tail.v_prv[3];
   assign match_in = (tail.is_verify && (tail.claimed == hash_in)) ||
                     (tail.prev_ok && (tail.claimed == hprv));

   assign ch_ready[SIP_ROUNDS] = !res_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (ch_ready[SIP_ROUNDS]) begin
         res_valid_ff <= ch_valid[SIP_ROUNDS];
      end
      if (ch_ready[SIP_ROUNDS] && ch_valid[SIP_ROUNDS]) begin
         hash_ff  <= hash_in;
         match_ff <= match_in;
      end
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {7'd0, match_ff, hash_ff};

endmodule

// File: hdl/shc_cell.sv
// One SipHash round cell: applies a round to the current and previous
// bucket states and hands the result on. Depends on shc_pkg.
module shc_cell #(
   parameter int unsigned RoundIdx = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  shc_pkg::cell_data_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output shc_pkg::cell_data_type out_data
);
   import shc_pkg::*;

   localparam logic       DoPre   = (RoundIdx < 8) && (RoundIdx % 2 == 0);
   localparam logic       DoPost  = (RoundIdx < 8) && (RoundIdx % 2 == 1);
   localparam logic       DoFin   = (RoundIdx == 7);
   localparam logic [1:0] WordSel = 2'((RoundIdx / 2) % 4);

   logic          valid_ff, valid_in;
   cell_data_type data_ff, data_in;

   // Stage may load when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Message injection, round, finalization constant
   always_comb begin
      data_in = in_data;
      if (DoPre) begin
         data_in.v_cur[3] = data_in.v_cur[3] ^ in_data.m_cur[WordSel];
         data_in.v_prv[3] = data_in.v_prv[3] ^ in_data.m_prv[WordSel];
      end
      data_in.v_cur = sip_round(data_in.v_cur);
      data_in.v_prv = sip_round(data_in.v_prv);
      if (DoPost) begin
         data_in.v_cur[0] = data_in.v_cur[0] ^ in_data.m_cur[WordSel];
         data_in.v_prv[0] = data_in.v_prv[0] ^ in_data.m_prv[WordSel];
      end
      if (DoFin) begin
         data_in.v_cur[2] = data_in.v_cur[2] ^ 64'hff;
         data_in.v_prv[2] = data_in.v_prv[2] ^ 64'hff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
